[rtl/core/record_sorter_by_key_defines.svh]
// Assertion macros shared by the record sorter RTL.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef RECORD_SORTER_BY_KEY_DEFINES_SVH
`define RECORD_SORTER_BY_KEY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RSK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record sorter check failed");

// Next-cycle implication, disabled during reset.
`define RSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record sorter check failed");

`endif

[rtl/core/rsk_pkg.sv]
// Package for the record sorter: record type, cell control struct,
// register indexes and sequencer states. No dependencies.
package rsk_pkg;

  localparam int ID_W  = 31;
  localparam int AMT_W = 31;
  localparam int TAG_W = 6;

  // Configuration register indexes
  localparam logic REG_SORT_KEY   = 1'b0;
  localparam logic REG_DESCENDING = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amount;
    logic [TAG_W-1:0] tag;
  } rsk_rec_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;       // write the incoming record into the cell at the fill position
    logic sort;       // compare-exchange pass in progress
    logic odd_phase;  // pairs (odd, odd+1) active when set, (even, even+1) when clear
    logic shift;      // move every record one cell toward cell 0
    logic key_id;     // compare ids when set, amounts when clear
    logic desc;       // descending order when set
  } rsk_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } rsk_state_t;

endpackage

[rtl/core/rsk_cell.sv]
// One sorter cell: holds a record, compares it with the upper neighbor.
// Depends on rsk_pkg.
module rsk_cell
  import rsk_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  rsk_ctrl_t        ctrl,
  input  logic [CNT_W-1:0] count,
  input  rsk_rec_t         in_rec,
  input  rsk_rec_t         up_rec,
  input  rsk_rec_t         lo_rec,
  input  logic             lo_swap,
  output rsk_rec_t         rec,
  output logic             swap_up
);

  localparam logic PAIR_ODD = ((INDEX % 2) == 1) ? 1'b1 : 1'b0;

  logic             self_valid;
  logic             up_valid;
  logic             wr_sel;
  logic [ID_W-1:0]  key_self;
  logic [ID_W-1:0]  key_up;
  logic             after;
  rsk_rec_t         rec_next;

  assign self_valid = CNT_W'(INDEX) < count;
  assign up_valid   = CNT_W'(INDEX + 1) < count;
  assign wr_sel     = ctrl.load && (count == CNT_W'(INDEX));

  assign key_self = ctrl.key_id ? rec.id : rec.amount;
  assign key_up   = ctrl.key_id ? up_rec.id : up_rec.amount;
  assign after    = ctrl.desc ? (key_self < key_up) : (key_self > key_up);

  // Exchange only when strictly out of order, so equal keys never cross
  assign swap_up = ctrl.sort && (ctrl.odd_phase == PAIR_ODD) &&
                   self_valid && up_valid && after;

  always_comb begin
    rec_next = rec;
    if (wr_sel) begin
      rec_next = in_rec;
    end else if (ctrl.shift) begin
      rec_next = up_rec;
    end else if (swap_up) begin
      rec_next = up_rec;
    end else if (lo_swap) begin
      rec_next = lo_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

[rtl/core/record_sorter_by_key.sv]
// Top level of the stable record sorter: sequencer plus a chain of rsk_cell.
// Depends on rsk_pkg, rsk_cell and record_sorter_by_key_defines.svh.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   input    | in_valid / in_stall | record_id, total_amount, record_tag, last_record
//   output   | out_valid/out_stall | sorted_id, sorted_amount, sorted_tag, last_out,
//            |                     | overflow
//   config   | cfg_we              | cfg_index, cfg_data
//
// Records load one per cycle into cell[fill_count]. After the record marked
// last, the chain runs n odd-even exchange passes (n = records held), one
// pass per cycle, then shifts out n results, one per transfer. Reset clears
// the sequencer, fill count, overflow flag and config; the cell contents need
// no clearing pass. in_stall stays high while sorting and emitting; a stalled
// result holds in cell 0 until transferred.
`include "record_sorter_by_key_defines.svh"

module record_sorter_by_key
  import rsk_pkg::*;
#(
  parameter int MAX_RECORDS = 64
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic             cfg_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ID_W-1:0]  record_id,
  input  logic [AMT_W-1:0] total_amount,
  input  logic [TAG_W-1:0] record_tag,
  input  logic             last_record,
  // output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  sorted_id,
  output logic [AMT_W-1:0] sorted_amount,
  output logic [TAG_W-1:0] sorted_tag,
  output logic             last_out,
  output logic             overflow
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // config registers and the values latched at the last record
  logic sort_key;
  logic descending;
  logic key_id;
  logic key_id_next;
  logic desc;
  logic desc_next;

  rsk_state_t       state;
  rsk_state_t       state_next;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic [CNT_W-1:0] phase_cnt;
  logic [CNT_W-1:0] phase_cnt_next;
  logic             dropped;
  logic             dropped_next;

  logic      in_xfer;
  logic      out_xfer;
  logic      full;
  logic      sort_done;
  rsk_ctrl_t ctrl;
  rsk_rec_t  in_rec;

  rsk_rec_t cell_rec [MAX_RECORDS];
  logic     cell_swap [MAX_RECORDS];

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign full      = fill_count >= CNT_W'(MAX_RECORDS);
  assign sort_done = phase_cnt == (fill_count - CNT_W'(1));

  assign in_rec.id     = record_id;
  assign in_rec.amount = total_amount;
  assign in_rec.tag    = record_tag;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key   <= 1'b0;
      descending <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SORT_KEY:   sort_key   <= cfg_data;
        REG_DESCENDING: descending <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_xfer && last_record) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (sort_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && (fill_count == CNT_W'(1))) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Sequencer outputs and cell control
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.sort      = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.odd_phase = phase_cnt[0];
    ctrl.key_id    = key_id;
    ctrl.desc      = desc;
    case (state)
      ST_LOAD: begin
        in_stall  = 1'b0;
        ctrl.load = in_valid && !full;
      end
      ST_SORT: begin
        ctrl.sort = 1'b1;
      end
      ST_EMIT: begin
        out_valid  = 1'b1;
        ctrl.shift = !out_stall;
      end
      default: ;
    endcase
  end

  // Counters, overflow flag and latched key/order
  always_comb begin
    fill_count_next = fill_count;
    phase_cnt_next  = phase_cnt;
    dropped_next    = dropped;
    key_id_next     = key_id;
    desc_next       = desc;
    case (state)
      ST_LOAD: begin
        phase_cnt_next = '0;
        if (in_xfer) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            fill_count_next = fill_count + CNT_W'(1);
          end
          if (last_record) begin
            key_id_next = sort_key;
            desc_next   = descending;
          end
        end
      end
      ST_SORT: begin
        phase_cnt_next = phase_cnt + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_xfer) begin
          fill_count_next = fill_count - CNT_W'(1);
          if (fill_count == CNT_W'(1)) dropped_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      phase_cnt  <= '0;
      dropped    <= 1'b0;
      key_id     <= 1'b0;
      desc       <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      phase_cnt  <= phase_cnt_next;
      dropped    <= dropped_next;
      key_id     <= key_id_next;
      desc       <= desc_next;
    end
  end

  // Cell chain: cell 0 faces the output, each cell talks to its neighbors
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rsk_rec_t up_rec;
    rsk_rec_t lo_rec;
    logic     lo_swap;

    if (i == MAX_RECORDS - 1) begin : g_top
      assign up_rec = '0;
    end else begin : g_mid
      assign up_rec = cell_rec[i+1];
    end

    if (i == 0) begin : g_bot
      assign lo_rec  = '0;
      assign lo_swap = 1'b0;
    end else begin : g_up
      assign lo_rec  = cell_rec[i-1];
      assign lo_swap = cell_swap[i-1];
    end

    rsk_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (fill_count),
      .in_rec  (in_rec),
      .up_rec  (up_rec),
      .lo_rec  (lo_rec),
      .lo_swap (lo_swap),
      .rec     (cell_rec[i]),
      .swap_up (cell_swap[i])
    );
  end

  // Result comes straight from cell 0
  assign sorted_id     = cell_rec[0].id;
  assign sorted_amount = cell_rec[0].amount;
  assign sorted_tag    = cell_rec[0].tag;
  assign last_out      = fill_count == CNT_W'(1);
  assign overflow      = dropped;

  // Checks
  `RSK_ASSERT_SAME(a_emit_nonempty, clk, rst, out_valid, fill_count != '0)
  `RSK_ASSERT_NEXT(a_drop_flags, clk, rst, in_xfer && full, dropped)
  `RSK_ASSERT_NEXT(a_batch_done, clk, rst, out_xfer && last_out,
                   (state == ST_LOAD) && (fill_count == '0) && !dropped)
  `RSK_ASSERT_SAME(a_no_load_while_busy, clk, rst, state != ST_LOAD, !ctrl.load)

endmodule
